// ===== rtl/core/rti_pkg.sv =====
// Shared widths, types and codes for the ray / triangle intersection pipeline.
`default_nettype none

package rti_pkg;

  // Coordinate format and derived exact widths
  localparam int COORD_BITS  = 16;
  localparam int DIFF_W      = COORD_BITS + 1;   // edge and origin offset
  localparam int HP_W        = COORD_BITS + DIFF_W;
  localparam int H_W         = HP_W + 1;         // d x e2
  localparam int QP_W        = 2 * DIFF_W;
  localparam int Q_W         = QP_W + 1;         // s x e1
  localparam int DP_W        = DIFF_W + Q_W;     // widest dot-product term
  localparam int SUM_W       = DP_W + 2;         // three-term dot product
  localparam int UV_W        = SUM_W + 1;        // u + v
  localparam int T_FRAC_BITS = 16;               // t_min is Q0.16
  localparam int TS_W        = SUM_W + T_FRAC_BITS;

  // Configuration register widths and reset values
  localparam int EPS_W    = 32;
  localparam int TMIN_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [EPS_W-1:0]  EPS_RESET  = 32'd168;
  localparam logic [TMIN_W-1:0] TMIN_RESET = 16'd1;

  // Stream payload widths
  localparam int IN_W        = 12 * COORD_BITS;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 4;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DET_EPSILON = 3'd3,
    REG_T_MIN       = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OC_HIT      = 3'd0,
    OC_PARALLEL = 3'd1,
    OC_U_OUT    = 3'd2,
    OC_V_OUT    = 3'd3,
    OC_T_NEAR   = 3'd4
  } outcome_t;

  typedef logic [2:0][COORD_BITS-1:0] vec_t;

  // Cross-product stage results with the vectors the dot stages still need
  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] d;
    logic [2:0][DIFF_W-1:0]     e1;
    logic [2:0][DIFF_W-1:0]     e2;
    logic [2:0][DIFF_W-1:0]     s;
    logic [2:0][H_W-1:0]        h;
    logic [2:0][Q_W-1:0]        q;
  } cross_t;

  // Determinant magnitude and sign-adjusted numerators
  typedef struct packed {
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] u;
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] t;
  } dot_t;

  // Cyclic component indices for the cross products
  function automatic int rot1(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int rot2(input int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rti_cross.sv =====
// Edge vectors and the two cross products, three pipeline stages.
`default_nettype none

module rti_cross
  import rti_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire vec_t   dir,
  input  wire vec_t   v0,
  input  wire vec_t   v1,
  input  wire vec_t   v2,
  input  wire vec_t   origin,
  output logic        out_valid,
  input  wire logic   out_ready,
  output cross_t      out
);

  logic [2:0] vld;
  logic [3:0] rdy;

  logic [2:0][COORD_BITS-1:0] d1, d2, d3;
  logic [2:0][DIFF_W-1:0]     e1_1, e2_1, s_1;
  logic [2:0][DIFF_W-1:0]     e1_2, e2_2, s_2;
  logic [2:0][DIFF_W-1:0]     e1_3, e2_3, s_3;
  logic [2:0][HP_W-1:0]       hpa, hpb;
  logic [2:0][QP_W-1:0]       qpa, qpb;
  logic [2:0][H_W-1:0]        h3;
  logic [2:0][Q_W-1:0]        q3;

  // A stage loads when it is empty or its successor takes its beat
  assign rdy[3] = out_ready;
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[2];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  // Stage 1: edges and origin offset
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        d1[i]   <= dir[i];
        e1_1[i] <= DIFF_W'($signed(v1[i])) - DIFF_W'($signed(v0[i]));
        e2_1[i] <= DIFF_W'($signed(v2[i])) - DIFF_W'($signed(v0[i]));
        s_1[i]  <= DIFF_W'($signed(origin[i])) - DIFF_W'($signed(v0[i]));
      end
    end
  end

  // Stage 2: cross-product partial products
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        hpa[i] <= $signed(d1[rot1(i)]) * $signed(e2_1[rot2(i)]);
        hpb[i] <= $signed(e2_1[rot1(i)]) * $signed(d1[rot2(i)]);
        qpa[i] <= $signed(s_1[rot1(i)]) * $signed(e1_1[rot2(i)]);
        qpb[i] <= $signed(e1_1[rot1(i)]) * $signed(s_1[rot2(i)]);
      end
      d2   <= d1;
      e1_2 <= e1_1;
      e2_2 <= e2_1;
      s_2  <= s_1;
    end
  end

  // Stage 3: h = d x e2, q = s x e1
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        h3[i] <= H_W'($signed(hpa[i])) - H_W'($signed(hpb[i]));
        q3[i] <= Q_W'($signed(qpa[i])) - Q_W'($signed(qpb[i]));
      end
      d3   <= d2;
      e1_3 <= e1_2;
      e2_3 <= e2_2;
      s_3  <= s_2;
    end
  end

  assign out.d  = d3;
  assign out.e1 = e1_3;
  assign out.e2 = e2_3;
  assign out.s  = s_3;
  assign out.h  = h3;
  assign out.q  = q3;

endmodule

`default_nettype wire

// ===== rtl/core/rti_dot.sv =====
// Determinant and numerator dot products with sign folding, three stages.
`default_nettype none

module rti_dot
  import rti_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire cross_t in,
  output logic        out_valid,
  input  wire logic   out_ready,
  output dot_t        out
);

  logic [2:0] vld;
  logic [3:0] rdy;

  logic [2:0][DP_W-1:0]    pa, pu, pv, pt;
  logic signed [SUM_W-1:0] sa, su, sv, st;
  dot_t                    res;

  assign rdy[3] = out_ready;
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[2];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  // Stage 4: per-component products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= $signed(in.e1[i]) * $signed(in.h[i]);
        pu[i] <= $signed(in.s[i])  * $signed(in.h[i]);
        pv[i] <= $signed(in.d[i])  * $signed(in.q[i]);
        pt[i] <= $signed(in.e2[i]) * $signed(in.q[i]);
      end
    end
  end

  // Stage 5: three-term sums
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sa <= SUM_W'($signed(pa[0])) + SUM_W'($signed(pa[1])) + SUM_W'($signed(pa[2]));
      su <= SUM_W'($signed(pu[0])) + SUM_W'($signed(pu[1])) + SUM_W'($signed(pu[2]));
      sv <= SUM_W'($signed(pv[0])) + SUM_W'($signed(pv[1])) + SUM_W'($signed(pv[2]));
      st <= SUM_W'($signed(pt[0])) + SUM_W'($signed(pt[1])) + SUM_W'($signed(pt[2]));
    end
  end

  // Stage 6: negate everything when the determinant is negative
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      if (sa[SUM_W-1]) begin
        res.a <= -sa;
        res.u <= -su;
        res.v <= -sv;
        res.t <= -st;
      end else begin
        res.a <= sa;
        res.u <= su;
        res.v <= sv;
        res.t <= st;
      end
    end
  end

  assign out = res;

endmodule

`default_nettype wire

// ===== rtl/core/rti_test.sv =====
// Bound tests and outcome selection, two stages ending in the output register.
`default_nettype none

module rti_test
  import rti_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dot_t              in,
  input  wire logic [EPS_W-1:0]  det_epsilon,
  input  wire logic [TMIN_W-1:0] t_min,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   hit,
  output outcome_t               outcome
);

  logic [1:0] vld;
  logic [2:0] rdy;

  logic                    par_fail, u_fail, v_fail;
  logic signed [TS_W-1:0]  t_shl;
  logic [TS_W-1:0]         a_tmin;
  logic signed [UV_W-1:0]  uv_sum;
  outcome_t                outcome_next;

  assign rdy[2] = out_ready;
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
    end
  end

  assign uv_sum = UV_W'(in.u) + UV_W'(in.v);

  // Stage 7: parallel, u and v tests; scale t and the distance bound
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      par_fail <= (in.a == '0) || ($unsigned(in.a) < SUM_W'(det_epsilon));
      u_fail   <= in.u[SUM_W-1] || (in.u > in.a);
      v_fail   <= in.v[SUM_W-1] || (uv_sum > UV_W'(in.a));
      t_shl    <= TS_W'(in.t) <<< T_FRAC_BITS;
      a_tmin   <= $unsigned(in.a) * t_min;
    end
  end

  // Report the first failing test in order
  always_comb begin
    if (par_fail) begin
      outcome_next = OC_PARALLEL;
    end else if (u_fail) begin
      outcome_next = OC_U_OUT;
    end else if (v_fail) begin
      outcome_next = OC_V_OUT;
    end else if (t_shl > $signed(a_tmin)) begin
      outcome_next = OC_HIT;
    end else begin
      outcome_next = OC_T_NEAR;
    end
  end

  // Stage 8: output register
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      outcome <= outcome_next;
      hit     <= (outcome_next == OC_HIT);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ray_triangle_intersect.sv =====
// Top level of the ray / triangle intersection block with its configuration registers.
//
// Use: each beat on the s_ channel carries a ray direction and the three
// vertices of one triangle; each beat on the m_ channel returns a hit flag
// and the code of the first failing test (parallel, u, v, distance). The ray
// origin, the determinant bound and the least hit distance sit in registers
// written through the cfg_ channel, one register per beat; cfg_ready is
// always high and writes to unknown indices are dropped. Write them only
// while no beat is in flight.
// Timing: an eight-stage pipeline that takes one beat in every cycle while
// m_tready is high. The depth is set by the two rounds of products (up to
// 17 by 17 bits, then up to 17 by 35 bits) and their sums.
// Reset: rst (synchronous) empties the pipeline and loads the registers
// with origin zero, det_epsilon 168 and t_min 1.
// Stall: each stage holds while it is full and its successor cannot take it, so when m_tready is
// low the pipeline fills up to eight beats before s_tready falls; no beat is
// lost or repeated.
`default_nettype none

module ray_triangle_intersect
  import rti_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata: dir_x, dir_y, dir_z, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
  //          v2_x, v2_y, v2_z (low to high)
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  // m_tdata: hit [0], outcome [3:1], zero padding
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_TDATA_W-1:0]     m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  vec_t              dir, v0, v1, v2, origin;
  logic [EPS_W-1:0]  det_epsilon;
  logic [TMIN_W-1:0] t_min;

  logic   cross_valid, cross_ready, dot_valid, dot_ready;
  cross_t cross_out;
  dot_t   dot_out;
  logic     hit;
  outcome_t outcome;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin      <= '0;
      det_epsilon <= EPS_RESET;
      t_min       <= TMIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin[0]   <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Y:    origin[1]   <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Z:    origin[2]   <= cfg_data[COORD_BITS-1:0];
        REG_DET_EPSILON: det_epsilon <= cfg_data[EPS_W-1:0];
        REG_T_MIN:       t_min       <= cfg_data[TMIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
      v0[i]  = s_tdata[(3+i)*COORD_BITS +: COORD_BITS];
      v1[i]  = s_tdata[(6+i)*COORD_BITS +: COORD_BITS];
      v2[i]  = s_tdata[(9+i)*COORD_BITS +: COORD_BITS];
    end
  end

  rti_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .dir       (dir),
    .v0        (v0),
    .v1        (v1),
    .v2        (v2),
    .origin    (origin),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .out       (cross_out)
  );

  rti_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_ready  (cross_ready),
    .in        (cross_out),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .out       (dot_out)
  );

  rti_test u_test (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dot_valid),
    .in_ready    (dot_ready),
    .in          (dot_out),
    .det_epsilon (det_epsilon),
    .t_min       (t_min),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .hit         (hit),
    .outcome     (outcome)
  );

  assign m_tdata = OUT_TDATA_W'({outcome, hit});

`ifndef NO_ASSERTIONS
  // A receiver that takes beats never stalls the sender
  a_ready_through: assert property (@(posedge clk) m_tready |-> s_tready)
    else $error("s_tready low while m_tready high");

  // Reset loads the register defaults
  a_cfg_reset: assert property (@(posedge clk)
    rst |=> (det_epsilon == EPS_RESET) && (t_min == TMIN_RESET) && (origin == '0))
    else $error("configuration registers not at reset values");

  // A t_min write lands in the next cycle
  a_tmin_write: assert property (@(posedge clk)
    !rst && cfg_valid && cfg_ready && (cfg_index == REG_T_MIN)
      |=> t_min == $past(cfg_data[TMIN_W-1:0]))
    else $error("t_min write lost");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for the ray / triangle intersection block: streams rays, checks each outcome.
`timescale 1ns / 100ps

module tb_top
  import rti_pkg::*;
();

  localparam int PIPE_DEPTH  = 8;      // pipeline depth in stages
  localparam int STALL_LIMIT = 2000;   // quiet cycles before the run is abandoned
  localparam int HOLD_CYCLES = 200;    // long receiver hold-off that backs the pipeline up
  localparam int MAX_GAP     = 11;
  localparam int UNIT        = 256;    // 1.0 in Q8.8
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  // One input beat; dir_x sits in the lowest bits
  typedef struct packed {
    logic [COORD_BITS-1:0] v2_z, v2_y, v2_x;
    logic [COORD_BITS-1:0] v1_z, v1_y, v1_x;
    logic [COORD_BITS-1:0] v0_z, v0_y, v0_x;
    logic [COORD_BITS-1:0] dir_z, dir_y, dir_x;
  } ray_tri_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Shadow copy of the configuration registers
  logic signed [COORD_BITS-1:0] org [3] = '{0, 0, 0};
  logic [EPS_W-1:0]             det_eps = EPS_RESET;
  logic [TMIN_W-1:0]            tmin    = TMIN_RESET;

  ray_tri_t pending_rays [$];
  outcome_t expected_outcomes [$];
  ray_tri_t offer;
  int       send_gap    = 0;
  int       recv_wait   = 0;
  int       hold_left   = 0;
  bit       press_done  = 1'b0;
  bit       press_start = 1'b0;
  bit       burst_mode  = 1'b0;
  int       mismatches  = 0;

  ray_triangle_intersect u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Exact Moller-Trumbore outcome with divisions turned into comparisons
  function automatic outcome_t classify_ray(input ray_tri_t it);
    longint d [3], p0 [3], p1 [3], p2 [3];
    longint e1 [3], e2 [3], s [3], h [3], q [3];
    longint a, u, v, t, eps_l;
    logic signed [95:0] t_scaled, a_scaled;
    bit flip;
    d[0]  = $signed(it.dir_x); d[1]  = $signed(it.dir_y); d[2]  = $signed(it.dir_z);
    p0[0] = $signed(it.v0_x);  p0[1] = $signed(it.v0_y);  p0[2] = $signed(it.v0_z);
    p1[0] = $signed(it.v1_x);  p1[1] = $signed(it.v1_y);  p1[2] = $signed(it.v1_z);
    p2[0] = $signed(it.v2_x);  p2[1] = $signed(it.v2_y);  p2[2] = $signed(it.v2_z);
    for (int i = 0; i < 3; i++) begin
      e1[i] = p1[i] - p0[i];
      e2[i] = p2[i] - p0[i];
      s[i]  = longint'(org[i]) - p0[i];
    end
    // Determinant from d x e2
    h[0] = d[1] * e2[2] - e2[1] * d[2];
    h[1] = d[2] * e2[0] - e2[2] * d[0];
    h[2] = d[0] * e2[1] - e2[0] * d[1];
    a = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    flip = (a < 0);
    if (flip) a = -a;
    eps_l = det_eps;
    if (a == 0 || a < eps_l) return OC_PARALLEL;
    u = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    if (flip) u = -u;
    if (u < 0 || u > a) return OC_U_OUT;
    q[0] = s[1] * e1[2] - e1[1] * s[2];
    q[1] = s[2] * e1[0] - e1[2] * s[0];
    q[2] = s[0] * e1[1] - e1[0] * s[1];
    v = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    if (flip) v = -v;
    if (v < 0 || u + v > a) return OC_V_OUT;
    t = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (flip) t = -t;
    // Compare t against t_min scaled by |a|, t_min being Q0.16
    t_scaled = t;
    t_scaled = t_scaled <<< T_FRAC_BITS;
    a_scaled = a;
    a_scaled = a_scaled * $signed({1'b0, tmin});
    if (t_scaled > a_scaled) return OC_HIT;
    return OC_T_NEAR;
  endfunction

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic ray_tri_t make_item(input int dx, dy, dz, ax, ay, az,
                                         bx, by, bz, cx, cy, cz);
    ray_tri_t it;
    it.dir_x = COORD_BITS'(dx); it.dir_y = COORD_BITS'(dy); it.dir_z = COORD_BITS'(dz);
    it.v0_x  = COORD_BITS'(ax); it.v0_y  = COORD_BITS'(ay); it.v0_z  = COORD_BITS'(az);
    it.v1_x  = COORD_BITS'(bx); it.v1_y  = COORD_BITS'(by); it.v1_z  = COORD_BITS'(bz);
    it.v2_x  = COORD_BITS'(cx); it.v2_y  = COORD_BITS'(cy); it.v2_z  = COORD_BITS'(cz);
    return it;
  endfunction

  // Ray from the origin towards the unit right triangle in the plane z = 1.0
  function automatic ray_tri_t flat_item(input int dx, dy, dz);
    return make_item(dx, dy, dz, 0, 0, UNIT, UNIT, 0, UNIT, 0, UNIT, UNIT);
  endfunction

  function automatic logic [COORD_BITS-1:0] any_coord();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic ray_tri_t noise_item();
    return {any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
            any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord()};
  endfunction

  // Vertex coordinate on a 1/16 grid, sometimes knocked off it
  function automatic int grid_coord();
    int c;
    c = ($urandom_range(0, 1000) - 500) * 16;
    if ($urandom_range(0, 3) == 0) c = c + $urandom_range(0, 15);
    return c;
  endfunction

  // Ray aimed at a barycentric point of a random triangle, scaled in distance
  function automatic ray_tri_t aimed_item();
    int vx [3][3];
    int w [3];
    int dd [3];
    int pt, k;
    bit over;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        vx[i][j] = grid_coord();
    w[1] = $urandom_range(0, 16);
    w[2] = $urandom_range(0, 16 - w[1]);
    w[0] = 16 - w[1] - w[2];
    k = $urandom_range(0, 10) - 2;
    over = 1'b0;
    for (int j = 0; j < 3; j++) begin
      pt = (w[0] * vx[0][j] + w[1] * vx[1][j] + w[2] * vx[2][j]) / 16;
      dd[j] = (pt - int'(org[j])) * k / 4;
      if (dd[j] > 32767 || dd[j] < -32768) over = 1'b1;
    end
    // Fall back to half the offset when the scaled direction does not fit
    if (over)
      for (int j = 0; j < 3; j++)
        dd[j] = ((w[0] * vx[0][j] + w[1] * vx[1][j] + w[2] * vx[2][j]) / 16
                 - int'(org[j])) / 2;
    if ($urandom_range(0, 4) == 0) dd[$urandom_range(0, 2)] += $urandom_range(0, 2) - 1;
    return make_item(dd[0], dd[1], dd[2], vx[0][0], vx[0][1], vx[0][2],
                     vx[1][0], vx[1][1], vx[1][2], vx[2][0], vx[2][1], vx[2][2]);
  endfunction

  // Collapsed triangles and rays lying in or near the triangle's plane
  function automatic ray_tri_t flat_or_collapsed_item();
    ray_tri_t it;
    int ax, ay, az, bx, by, bz;
    it = aimed_item();
    ax = $signed(it.v0_x); ay = $signed(it.v0_y); az = $signed(it.v0_z);
    bx = $signed(it.v1_x); by = $signed(it.v1_y); bz = $signed(it.v1_z);
    case ($urandom_range(0, 4))
      0: begin it.v1_x = it.v0_x; it.v1_y = it.v0_y; it.v1_z = it.v0_z; end
      1: begin it.v2_x = it.v0_x; it.v2_y = it.v0_y; it.v2_z = it.v0_z; end
      2: begin
        it.dir_x = COORD_BITS'(bx - ax);
        it.dir_y = COORD_BITS'(by - ay);
        it.dir_z = COORD_BITS'(bz - az);
      end
      3: begin it.dir_x = '0; it.dir_y = '0; it.dir_z = '0; end
      default: begin
        it.dir_x = COORD_BITS'(bx - ax + $urandom_range(0, 2) - 1);
        it.dir_y = COORD_BITS'(by - ay + $urandom_range(0, 2) - 1);
        it.dir_z = COORD_BITS'(bz - az + $urandom_range(0, 2) - 1);
      end
    endcase
    return it;
  endfunction

  // Write one register once the channel takes the beat; call at a rising edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X:    org[0]  = val[COORD_BITS-1:0];
      REG_ORIGIN_Y:    org[1]  = val[COORD_BITS-1:0];
      REG_ORIGIN_Z:    org[2]  = val[COORD_BITS-1:0];
      REG_DET_EPSILON: det_eps = val[EPS_W-1:0];
      REG_T_MIN:       tmin    = val[TMIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  // Block until every queued ray has gone through and been checked
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_rays.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] origin_word(input int c);
    return {16'($urandom), COORD_BITS'(c)};
  endfunction

  task automatic random_config();
    int c;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0:       c = -32768;
        1:       c = 32767;
        default: c = $urandom_range(0, 16000) - 8000;
      endcase
      cfg_write(cfg_reg_t'(REG_ORIGIN_X + i), origin_word(c));
    end
    case ($urandom_range(0, 4))
      0:       cfg_write(REG_DET_EPSILON, 32'd0);
      1:       cfg_write(REG_DET_EPSILON, $urandom_range(0, 255));
      2:       cfg_write(REG_DET_EPSILON, 32'd1 << $urandom_range(0, 31));
      default: cfg_write(REG_DET_EPSILON, $urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       cfg_write(REG_T_MIN, 32'd0);
      1:       cfg_write(REG_T_MIN, 32'hFFFF);
      default: cfg_write(REG_T_MIN, $urandom);
    endcase
    if ($urandom_range(0, 2) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
    cfg_done();
  endtask

  function automatic ray_tri_t mixed_item();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return aimed_item();
      6, 7:             return noise_item();
      default:          return flat_or_collapsed_item();
    endcase
  endfunction

  // Driver: offer queued rays, hold each until taken, then wait a drawn gap
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_outcomes.push_back(classify_ray(offer));
        send_gap = draw_gap();
      end
      if (send_gap != 0 || pending_rays.size() == 0) begin
        if (send_gap != 0) send_gap--;
        s_tvalid <= 1'b0;
      end else begin
        offer = pending_rays.pop_front();
        s_tdata  <= IN_TDATA_W'(offer);
        s_tvalid <= 1'b1;
      end
    end
  end

  // Monitor: check each result beat, then stall the output for a drawn gap
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result beat with nothing expected: tdata %h", m_tdata);
          mismatches++;
        end else begin
          outcome_t want;
          want = expected_outcomes.pop_front();
          if (m_tdata[0] !== (want == OC_HIT)) begin
            $error("hit: expected %0d, actual %0d", want == OC_HIT, m_tdata[0]);
            mismatches++;
          end
          if (m_tdata[3:1] !== want) begin
            $error("outcome: expected %0d, actual %0d", want, m_tdata[3:1]);
            mismatches++;
          end
          if (m_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
            $error("padding: expected 0, actual %h", m_tdata[OUT_TDATA_W-1:OUT_W]);
            mismatches++;
          end
        end
        recv_wait = draw_gap();
      end
      if (press_start && !press_done) begin
        press_done = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when no channel moves a beat for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus: directed rays, then phases of random rays under varied settings
  initial begin : stimulus
    int n_items;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: interior, corners, edges, each rejection, flipped winding
    pending_rays.push_back(flat_item(64, 64, UNIT));
    pending_rays.push_back(flat_item(0, 0, UNIT));
    pending_rays.push_back(flat_item(UNIT, 0, UNIT));
    pending_rays.push_back(flat_item(0, UNIT, UNIT));
    pending_rays.push_back(flat_item(128, 128, UNIT));
    pending_rays.push_back(flat_item(-1, 64, UNIT));
    pending_rays.push_back(flat_item(300, 0, UNIT));
    pending_rays.push_back(flat_item(64, -1, UNIT));
    pending_rays.push_back(flat_item(200, 100, UNIT));
    pending_rays.push_back(flat_item(-64, -64, -UNIT));
    pending_rays.push_back(make_item(64, 64, UNIT, 0, 0, UNIT, 0, UNIT, UNIT, UNIT, 0, UNIT));
    pending_rays.push_back(make_item(64, 64, UNIT, 0, 0, UNIT, 0, 0, UNIT, 0, UNIT, UNIT));
    pending_rays.push_back(flat_item(UNIT, 0, 0));
    pending_rays.push_back(make_item(32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 32767, 32767, 32767));
    pending_rays.push_back(make_item(-32768, -32768, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768, -32768, -32768));
    pending_rays.push_back(make_item(32767, -32768, 32767, -32768, -32768, 32767,
                                     32767, -32768, -32768, -32768, 32767, -32768));
    wait_drained();

    // Hit distance exactly at, just above and just below t_min = 0.5
    cfg_write(REG_T_MIN, 32'h8000);
    cfg_done();
    pending_rays.push_back(flat_item(0, 0, 2 * UNIT));
    pending_rays.push_back(flat_item(0, 0, 2 * UNIT - 1));
    pending_rays.push_back(flat_item(0, 0, 2 * UNIT + 1));
    wait_drained();

    // Zero determinant stays parallel with no bound; tiny triangle has |a| = 256
    cfg_write(REG_DET_EPSILON, 32'd0);
    cfg_done();
    pending_rays.push_back(make_item(64, 64, UNIT, 0, 0, UNIT, 0, 0, UNIT, 0, UNIT, UNIT));
    pending_rays.push_back(make_item(0, 0, UNIT, 0, 0, UNIT, 1, 0, UNIT, 0, 1, UNIT));
    wait_drained();
    cfg_write(REG_DET_EPSILON, 32'd257);
    cfg_done();
    pending_rays.push_back(make_item(0, 0, UNIT, 0, 0, UNIT, 1, 0, UNIT, 0, 1, UNIT));
    wait_drained();
    // Bound equal to |a| passes; a write to a spare index changes nothing
    cfg_write(REG_DET_EPSILON, 32'd256);
    cfg_write(REG_SPARE_FIRST, 32'hFFFF_FFFF);
    cfg_done();
    pending_rays.push_back(make_item(0, 0, UNIT, 0, 0, UNIT, 1, 0, UNIT, 0, 1, UNIT));
    wait_drained();

    // Extreme settings: largest bound and t_min, origin at a corner
    cfg_write(REG_ORIGIN_X, origin_word(-32768));
    cfg_write(REG_ORIGIN_Y, origin_word(32767));
    cfg_write(REG_ORIGIN_Z, origin_word(-32768));
    cfg_write(REG_DET_EPSILON, 32'hFFFF_FFFF);
    cfg_write(REG_T_MIN, 32'hFFFF_FFFF);
    cfg_done();
    repeat (30) pending_rays.push_back(mixed_item());
    wait_drained();

    cfg_write(REG_ORIGIN_X, origin_word(32767));
    cfg_write(REG_ORIGIN_Y, origin_word(-32768));
    cfg_write(REG_ORIGIN_Z, origin_word(0));
    cfg_write(REG_DET_EPSILON, 32'd0);
    cfg_write(REG_T_MIN, 32'd0);
    cfg_done();
    repeat (40) pending_rays.push_back(mixed_item());
    wait_drained();

    // Random phases; alternate idling, and in one hold the output off for long
    for (int p = 0; p < 7; p++) begin
      random_config();
      burst_mode = p[0];
      n_items = 60;
      if (p == 3) begin
        burst_mode = 1'b1;
        press_start <= 1'b1;
        n_items = 80;
      end
      repeat (n_items) pending_rays.push_back(mixed_item());
      wait_drained();
    end

    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
